/* rtl/core/cps_pkg.sv */
// cps_pkg: shared constants, transaction types and bit-level helper functions
// for the challenge/response scrambler. Depends on nothing.
`default_nettype none

package cps_pkg;

    // Scramble mask, generator seeding word and warm-up length
    localparam logic [63:0] SCR_MASK      = 64'h8E55AA1B3999E8AA;
    localparam logic [31:0] SEED_A        = 32'hF1EA5EED;
    localparam int          WARMUP_ROUNDS = 23;
    localparam int          ROUND_CNT_W   = $clog2(WARMUP_ROUNDS);
    localparam int          ROT_B         = 27;
    localparam int          ROT_C         = 17;

    // Reply frame constants
    localparam logic [7:0] FRAME_HEAD   = 8'hAA;
    localparam logic [3:0] LEN_RESPONSE = 4'h9;
    localparam logic [3:0] LEN_ACK      = 4'h1;
    localparam logic       FILLER_BIT   = 1'b0;

    // Request kinds
    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_NEXT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  sequence_req;
        logic [63:0] challenge;
    } req_t;

    typedef struct packed {
        logic [3:0]  reply_length;
        logic [63:0] payload;
        logic [7:0]  frame_checksum;
    } rsp_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } gen_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic round;
        logic write;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } sts_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
        return (x << k) | (x >> (32 - k));
    endfunction

    // One small-fast generator round
    function automatic gen_t gen_round(input gen_t g);
        gen_t        n;
        logic [31:0] e;
        e   = g.a - rotl(g.b, ROT_B);
        n.a = g.b ^ rotl(g.c, ROT_C);
        n.b = g.c + g.d;
        n.c = g.d + e;
        n.d = e + n.a;
        return n;
    endfunction

    // Gather the challenge bits under the reversed mask, first kept bit at the MSB
    function automatic logic [31:0] gather_bits(input logic [63:0] v);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) begin
            if (SCR_MASK[63 - i]) begin
                r = {r[30:0], v[i]};
            end
        end
        return r;
    endfunction

    // Scatter a value under the reversed mask, LSB first from the top bit downward
    function automatic logic [63:0] scatter_bits(input logic [31:0] v);
        logic [63:0] r;
        logic [31:0] w;
        r = '0;
        w = v;
        for (int i = 0; i < 64; i++) begin
            if (SCR_MASK[i]) begin
                r[63 - i] = w[0];
                w = w >> 1;
            end else begin
                r[63 - i] = FILLER_BIT;
            end
        end
        return r;
    endfunction

    // Byte-sum checksum of the reply frame
    function automatic logic [7:0] frame_sum(input logic [3:0] len, input logic [7:0] seq,
                                             input logic [63:0] p);
        logic [7:0] s;
        s = FRAME_HEAD + {4'h0, len} + seq;
        for (int k = 0; k < 8; k++) begin
            s = s + p[8 * k +: 8];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/challenge_prng_scrambler.sv */
// A seed transaction, once accepted, runs 23 warm-up rounds in the shared round
// unit and then forms the reply frame in the output register; a next transaction
// runs one round and then forms the frame. The frame waits for a free register.
// One transaction at a time: a new request is stalled until the reply is written.
// Reset clears the generator words to zero and empties the output register.
`default_nettype none

module challenge_prng_scrambler (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire cps_pkg::req_t req_data,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output cps_pkg::rsp_t      rsp_data
);

    cps_pkg::cmd_t cmd;
    cps_pkg::sts_t sts;

    cps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req_data.kind),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cps_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire

/* rtl/core/cps_ctrl.sv */
// cps_ctrl: sequencing state machine for the scrambler; issues load, round
// and write commands to cps_datapath. Depends on cps_pkg.
`default_nettype none

module cps_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    input  wire logic         req_kind,
    output logic              req_stall,
    input  wire cps_pkg::sts_t sts,
    output cps_pkg::cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WARM   = 2'd1;
    localparam logic [1:0] ST_STEP   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [cps_pkg::ROUND_CNT_W-1:0] LAST_ROUND =
        cps_pkg::ROUND_CNT_W'(cps_pkg::WARMUP_ROUNDS - 1);

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [cps_pkg::ROUND_CNT_W-1:0] cnt_reg;
    logic [cps_pkg::ROUND_CNT_W-1:0] cnt_next;
    logic                            accept;

    // Take a new transaction only when idle
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;

    // Drive datapath commands
    always_comb
    begin
        cmd.load  = accept;
        cmd.round = (state_reg == ST_WARM) || (state_reg == ST_STEP);
        cmd.write = (state_reg == ST_FINISH) && sts.out_free;
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = (req_kind == cps_pkg::KIND_SEED) ? ST_WARM : ST_STEP;
                end
            end
            ST_WARM:
            begin
                if (cnt_reg == LAST_ROUND)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_STEP:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cps_datapath.sv */
// cps_datapath: generator state, descramble/scramble networks, checksum and
// the output register of the scrambler. Depends on cps_pkg.
`default_nettype none

module cps_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cps_pkg::req_t req_data,
    input  wire cps_pkg::cmd_t cmd,
    output cps_pkg::sts_t      sts,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output cps_pkg::rsp_t      rsp_data
);

    cps_pkg::gen_t gen_reg;
    cps_pkg::gen_t gen_next;
    cps_pkg::gen_t gen_step;
    logic [31:0]   seed;
    logic [31:0]   val_reg;
    logic          kind_reg;
    logic [7:0]    seq_reg;
    logic          valid_reg;
    cps_pkg::rsp_t rsp_reg;
    cps_pkg::rsp_t rsp_next;

    assign sts.out_free = !valid_reg || !rsp_stall;
    assign rsp_valid    = valid_reg;
    assign rsp_data     = rsp_reg;

    // Descramble the challenge and run one generator round
    assign seed     = cps_pkg::gather_bits(req_data.challenge);
    assign gen_step = cps_pkg::gen_round(gen_reg);

    // Select the next generator state
    always_comb
    begin
        gen_next = gen_reg;
        if (cmd.load && (req_data.kind == cps_pkg::KIND_SEED))
        begin
            gen_next.a = cps_pkg::SEED_A;
            gen_next.b = seed;
            gen_next.c = seed;
            gen_next.d = seed;
        end
        else if (cmd.round)
        begin
            gen_next = gen_step;
        end
    end

    // Form the reply frame
    always_comb
    begin
        if (kind_reg == cps_pkg::KIND_NEXT)
        begin
            rsp_next.reply_length = cps_pkg::LEN_RESPONSE;
            rsp_next.payload      = cps_pkg::scatter_bits(val_reg);
        end
        else
        begin
            rsp_next.reply_length = cps_pkg::LEN_ACK;
            rsp_next.payload      = '0;
        end
        rsp_next.frame_checksum = cps_pkg::frame_sum(rsp_next.reply_length, seq_reg,
                                                     rsp_next.payload);
    end

    // Hold generator state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            gen_reg <= gen_next;
            if (cmd.write)
            begin
                valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Capture transaction fields, round value and reply
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= req_data.kind;
            seq_reg  <= req_data.sequence_req;
        end
        if (cmd.round)
        begin
            val_reg <= gen_step.d;
        end
        if (cmd.write)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cps_checker.sv */
// cps_checker: port-level assertions for challenge_prng_scrambler, attached by
// bind. Depends on cps_pkg.
`default_nettype none

module cps_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire cps_pkg::req_t req_data,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire cps_pkg::rsp_t rsp_data
);

    // One transaction in flight: busy straight after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while a transaction was in flight");

    // No reply in the cycle after a request is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> !$rose(rsp_valid))
        else $error("reply appeared too early");

    // Reply is an acknowledge with empty payload or a full response
    a_reply_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.reply_length == cps_pkg::LEN_ACK && rsp_data.payload == '0)
                   || (rsp_data.reply_length == cps_pkg::LEN_RESPONSE))
        else $error("malformed reply frame");

    // Stalled reply holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled reply changed");

    // Stalled request holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_data))
        else $error("stalled request changed");

endmodule

bind challenge_prng_scrambler cps_checker u_cps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire
